FILE: rtl/core/ppu_pkg.sv
// ppu_pkg: shared types and constants of the palette pixel upscaler
// used by ppu_front, ppu_queue, ppu_back and palette_pixel_upscaler_top
`default_nettype none

package ppu_pkg;

  // frame geometry
  localparam int unsigned FrameWidth  = 854;
  localparam int unsigned FrameHeight = 480;
  localparam int unsigned ColW        = 10;
  localparam int unsigned RowW        = 9;

  // palette
  localparam int unsigned PalDepth    = 256;
  localparam int unsigned PalIdxW     = 8;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned RgbW        = 3 * ChanW;

  // transparency register
  localparam int unsigned TranspW     = 9;
  localparam logic [TranspW-1:0] TranspNone = 9'h100;

  // result fields
  localparam int unsigned PosXW       = 11;
  localparam int unsigned PosYW       = 10;
  localparam int unsigned ColorW      = 32;
  localparam logic [ChanW-1:0] AlphaOpaque = 8'hff;

  // queue between front and back
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdPixel = 1'b1
  } cmd_e;

  typedef enum logic {
    ScreenMain   = 1'b0,
    ScreenNative = 1'b1
  } screen_e;

  // write sequence for one opaque pixel
  typedef enum logic [2:0] {
    PhMainTl = 3'd0,
    PhMainTr = 3'd1,
    PhMainBr = 3'd2,
    PhMainBl = 3'd3,
    PhNative = 3'd4
  } phase_e;

  // one opaque pixel, ready to be drawn
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [RgbW-1:0] rgb;
  } pix_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/palette_pixel_upscaler_top.sv
// palette_pixel_upscaler_top: top level joining front, queue and back
// depends on ppu_pkg, ppu_front, ppu_queue, ppu_back
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  input    | in_valid_i/in_ready_o  | command, entry_number, rgb, pixel_value
//  output   | out_valid_o/out_ready_i| screen_select, pos_x, pos_y, color_word, last
//  config   | cfg_we_i               | cfg_wdata_i (transparent index)
//
// an opaque pixel gives five writes, one per cycle while out_ready_i is high, so
// pixel throughput is set by the single output port; loads and transparent pixels
// give no writes; a pixel's first write is offered after it passes the palette read
// register, the queue and the write register
// the two-entry queue lets the front keep accepting while the output is stalled
// no clearing pass after reset; the palette is undefined until loaded
`default_nettype none

module palette_pixel_upscaler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ppu_pkg::TranspW-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          command_i,
  input  wire logic [ppu_pkg::PalIdxW-1:0]   entry_number_i,
  input  wire logic [ppu_pkg::ChanW-1:0]     red_in_i,
  input  wire logic [ppu_pkg::ChanW-1:0]     green_in_i,
  input  wire logic [ppu_pkg::ChanW-1:0]     blue_in_i,
  input  wire logic [ppu_pkg::PalIdxW-1:0]   pixel_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               screen_select_o,
  output logic [ppu_pkg::PosXW-1:0]          pos_x_o,
  output logic [ppu_pkg::PosYW-1:0]          pos_y_o,
  output logic [ppu_pkg::ColorW-1:0]         color_word_o,
  output logic                               last_write_o
);

  logic                push, q_full, q_valid, pop;
  ppu_pkg::pix_entry_t push_data, pop_data;

  ppu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .entry_number_i (entry_number_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .pixel_value_i  (pixel_value_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .q_full_i       (q_full)
  );

  ppu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (q_valid)
  );

  ppu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .screen_select_o (screen_select_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .color_word_o    (color_word_o),
    .last_write_o    (last_write_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ppu_front.sv
// ppu_front: input handshake, palette memory, transparency check and raster counters
// depends on ppu_pkg; feeds ppu_queue
`default_nettype none

module ppu_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [ppu_pkg::TranspW-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            command_i,
  input  wire logic [ppu_pkg::PalIdxW-1:0]     entry_number_i,
  input  wire logic [ppu_pkg::ChanW-1:0]       red_in_i,
  input  wire logic [ppu_pkg::ChanW-1:0]       green_in_i,
  input  wire logic [ppu_pkg::ChanW-1:0]       blue_in_i,
  input  wire logic [ppu_pkg::PalIdxW-1:0]     pixel_value_i,
  // queue push side
  output logic                                 push_o,
  output ppu_pkg::pix_entry_t                  push_data_o,
  input  wire logic                            q_full_i
);

  logic [ppu_pkg::TranspW-1:0] transp_q;
  logic [ppu_pkg::RgbW-1:0]    pal_mem [ppu_pkg::PalDepth];
  logic [ppu_pkg::RgbW-1:0]    rgb_q;
  logic [ppu_pkg::ColW-1:0]    col_q, col_d, s1_col_q;
  logic [ppu_pkg::RowW-1:0]    row_q, row_d, s1_row_q;
  logic [ppu_pkg::ColW-1:0]    col_inc;
  logic [ppu_pkg::RowW-1:0]    row_inc;
  logic                        s1_valid_q, s1_valid_d;
  logic                        accept, is_pixel, opaque, take_pixel;

  // transparency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_q <= ppu_pkg::TranspNone;
    end else if (cfg_we_i) begin
      transp_q <= cfg_wdata_i;
    end
  end

  // classify the incoming item
  assign in_ready_o = !s1_valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (ppu_pkg::cmd_e'(command_i) == ppu_pkg::CmdPixel);
  assign opaque     = ({1'b0, pixel_value_i} != transp_q);
  assign take_pixel = accept && is_pixel && opaque;

  // palette memory, registered read
  always_ff @(posedge clk_i) begin
    if (accept && !is_pixel) begin
      pal_mem[entry_number_i] <= {red_in_i, green_in_i, blue_in_i};
    end
    if (take_pixel) begin
      rgb_q    <= pal_mem[pixel_value_i];
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // lookup stage valid
  assign push_o = s1_valid_q && !q_full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_pixel) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  assign push_data_o.col = s1_col_q;
  assign push_data_o.row = s1_row_q;
  assign push_data_o.rgb = rgb_q;

  // raster counters, advance on every pixel
  assign col_inc = col_q + ppu_pkg::ColW'(1);
  assign row_inc = row_q + ppu_pkg::RowW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && is_pixel) begin
      col_d = col_inc;
      if (col_inc >= ppu_pkg::ColW'(ppu_pkg::FrameWidth)) begin
        col_d = '0;
        row_d = row_inc;
        if (row_inc >= ppu_pkg::RowW'(ppu_pkg::FrameHeight)) begin
          row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppu_queue.sv
// ppu_queue: short register queue of looked-up pixels between front and back
// depends on ppu_pkg
`default_nettype none

module ppu_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  ppu_pkg::pix_entry_t      push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output ppu_pkg::pix_entry_t      pop_data_o,
  output logic                     valid_o
);

  ppu_pkg::pix_entry_t               slot_q [ppu_pkg::QueueDepth];
  logic [ppu_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ppu_pkg::QueueCntW-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == ppu_pkg::QueueCntW'(ppu_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + ppu_pkg::QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - ppu_pkg::QueueCntW'(1);
    end
  end

  // pointers wrap at the queue depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == ppu_pkg::QueuePtrW'(ppu_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + ppu_pkg::QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == ppu_pkg::QueuePtrW'(ppu_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + ppu_pkg::QueuePtrW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue pop while empty");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + ppu_pkg::QueueCntW'(1)))
    else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ppu_back.sv
// ppu_back: expands one queued pixel into four upscaled writes and one native write
// depends on ppu_pkg; drains ppu_queue
`default_nettype none

module ppu_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // queue pop side
  input  wire logic                          q_valid_i,
  input  ppu_pkg::pix_entry_t                q_data_i,
  output logic                               pop_o,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               screen_select_o,
  output logic [ppu_pkg::PosXW-1:0]          pos_x_o,
  output logic [ppu_pkg::PosYW-1:0]          pos_y_o,
  output logic [ppu_pkg::ColorW-1:0]         color_word_o,
  output logic                               last_write_o
);

  ppu_pkg::pix_entry_t       cur_q;
  logic                      cur_valid_q, cur_valid_d;
  ppu_pkg::phase_e           phase_q, phase_d;
  logic                      out_xfer;
  logic [ppu_pkg::PosXW:0]   col_x3;
  logic [ppu_pkg::PosYW:0]   row_x3;
  logic [ppu_pkg::PosXW-1:0] bx;
  logic [ppu_pkg::PosYW-1:0] by;

  assign out_valid_o = cur_valid_q;
  assign out_xfer    = cur_valid_q && out_ready_i;
  assign pop_o       = q_valid_i &&
                       (!cur_valid_q || (out_xfer && phase_q == ppu_pkg::PhNative));

  // next phase
  always_comb begin
    phase_d     = phase_q;
    cur_valid_d = cur_valid_q;
    if (pop_o) begin
      phase_d     = ppu_pkg::PhMainTl;
      cur_valid_d = 1'b1;
    end else if (out_xfer) begin
      unique case (phase_q)
        ppu_pkg::PhMainTl: phase_d = ppu_pkg::PhMainTr;
        ppu_pkg::PhMainTr: phase_d = ppu_pkg::PhMainBr;
        ppu_pkg::PhMainBr: phase_d = ppu_pkg::PhMainBl;
        ppu_pkg::PhMainBl: phase_d = ppu_pkg::PhNative;
        ppu_pkg::PhNative: begin
          phase_d     = ppu_pkg::PhMainTl;
          cur_valid_d = 1'b0;
        end
        default: phase_d = ppu_pkg::PhMainTl;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ppu_pkg::PhMainTl;
      cur_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cur_valid_q <= cur_valid_d;
    end
  end

  // current pixel payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // upscaled origin: 3x/2, 3y/2
  assign col_x3 = {2'b00, cur_q.col} + {1'b0, cur_q.col, 1'b0};
  assign row_x3 = {2'b00, cur_q.row} + {1'b0, cur_q.row, 1'b0};
  assign bx     = col_x3[ppu_pkg::PosXW:1];
  assign by     = row_x3[ppu_pkg::PosYW:1];

  assign color_word_o = {cur_q.rgb, ppu_pkg::AlphaOpaque};

  // write position per phase
  always_comb begin
    screen_select_o = ppu_pkg::ScreenMain;
    last_write_o    = 1'b0;
    pos_x_o         = bx;
    pos_y_o         = by;
    unique case (phase_q)
      ppu_pkg::PhMainTl: begin
        pos_x_o = bx;
        pos_y_o = by;
      end
      ppu_pkg::PhMainTr: begin
        pos_x_o = bx + ppu_pkg::PosXW'(1);
        pos_y_o = by;
      end
      ppu_pkg::PhMainBr: begin
        pos_x_o = bx + ppu_pkg::PosXW'(1);
        pos_y_o = by + ppu_pkg::PosYW'(1);
      end
      ppu_pkg::PhMainBl: begin
        pos_x_o = bx;
        pos_y_o = by + ppu_pkg::PosYW'(1);
      end
      ppu_pkg::PhNative: begin
        screen_select_o = ppu_pkg::ScreenNative;
        last_write_o    = 1'b1;
        pos_x_o         = {{(ppu_pkg::PosXW - ppu_pkg::ColW){1'b0}}, cur_q.col};
        pos_y_o         = {{(ppu_pkg::PosYW - ppu_pkg::RowW){1'b0}}, cur_q.row};
      end
      default: begin
        pos_x_o = bx;
        pos_y_o = by;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (cur_valid_q && phase_q == ppu_pkg::PhMainTl))
    else $error("popped pixel did not start at first write");

  a_phase_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && phase_q != ppu_pkg::PhNative) |=>
      (phase_q == ppu_pkg::phase_e'($past(phase_q) + 3'd1)))
    else $error("write sequence skipped a step");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && !out_ready_i) |=> (cur_valid_q && $stable(phase_q)))
    else $error("write sequence moved while stalled");
`endif

endmodule

`default_nettype wire
